// ----- rtl/pqd_pkg.sv -----
package pqd_pkg;

   // Packed word layout
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned COMP_W      = 10;
   localparam int unsigned NUM_COMP    = 3;
   localparam int unsigned LANE_IDX_W  = 2;
   localparam logic [COMP_W-1:0] COMP_OFFSET = 10'd512;

   // Component scale, about 1/(sqrt2*511), as SCALE_NUM / 2^34
   localparam int unsigned SCALE_W     = 25;
   localparam logic [SCALE_W-1:0] SCALE_NUM = 25'd23772998;
   localparam int unsigned PROD_W      = COMP_W + SCALE_W;
   localparam int unsigned ROUND_SHIFT = 19;
   localparam int unsigned MAG_Q_W     = 15;

   // Squared scale, rounded to 2^-20 units of SCALE_NUM^2
   localparam logic [63:0] SCALE_SQ_WIDE =
      ((64'(SCALE_NUM) * 64'(SCALE_NUM)) + (64'd1 << 19)) >> 20;
   localparam int unsigned SCALE_SQ_W  = 30;
   localparam logic [SCALE_SQ_W-1:0] SCALE_SQ = SCALE_SQ_WIDE[SCALE_SQ_W-1:0];

   // Sum of squares and radicand
   localparam int unsigned SQ_W        = 19;
   localparam int unsigned SUMSQ_W     = 20;
   localparam int unsigned TERM_PROD_W = SUMSQ_W + SCALE_SQ_W;
   localparam int unsigned TERM_SHIFT  = 18;
   localparam int unsigned RAD_W       = 32;
   localparam int unsigned ROOT_ACC_W  = 31;
   localparam int unsigned SQRT_STEPS  = 16;

   // Lanes
   localparam int unsigned LANE_W      = 16;
   localparam logic signed [LANE_W-1:0] LANE_MAX = 16'sd32767;
   localparam logic signed [LANE_W-1:0] LANE_MIN = -16'sd32768;

   // Status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_NEG = 1'b1;

   // Front queue depth
   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   typedef struct packed {
      logic [WORD_W-1:0] packed_word;
      logic              mirror;
   } pqd_req_type;

   typedef struct packed {
      logic                     status;
      logic [LANE_IDX_W-1:0]    omitted_lane;
      logic signed [RAD_W-1:0]  radicand;
      logic signed [LANE_W-1:0] lane_0;
      logic signed [LANE_W-1:0] lane_1;
      logic signed [LANE_W-1:0] lane_2;
      logic signed [LANE_W-1:0] lane_3;
   } pqd_rsp_type;

   // Classified item passed from front to back
   typedef struct packed {
      logic [LANE_IDX_W-1:0]           omitted;
      logic                            mirror;
      logic [NUM_COMP-1:0]             neg;
      logic [NUM_COMP-1:0][PROD_W-1:0] prod;
      logic [NUM_COMP-1:0][SQ_W-1:0]   sq;
   } pqd_item_type;

endpackage

// ----- rtl/pqd_front.sv -----
module pqd_front (
   input  pqd_pkg::pqd_req_type  req_data,
   output pqd_pkg::pqd_item_type item
);
   import pqd_pkg::*;

   logic [NUM_COMP-1:0][COMP_W-1:0] field;
   logic [NUM_COMP-1:0][COMP_W-1:0] mag;

   // Split the word, most significant component first
   always_comb begin
      for (int i = 0; i < NUM_COMP; i++) begin
         field[i] = req_data.packed_word[(NUM_COMP-1-i)*COMP_W +: COMP_W];
      end
   end

   // Remove the offset as sign and magnitude, then scale and square
   always_comb begin
      item.omitted = req_data.packed_word[WORD_W-1 -: LANE_IDX_W];
      item.mirror  = req_data.mirror;
      for (int i = 0; i < NUM_COMP; i++) begin
         item.neg[i]  = ~field[i][COMP_W-1];
         mag[i]       = field[i][COMP_W-1] ? (field[i] - COMP_OFFSET)
                                           : (COMP_OFFSET - field[i]);
         item.prod[i] = PROD_W'(mag[i]) * PROD_W'(SCALE_NUM);
         item.sq[i]   = SQ_W'(mag[i]) * SQ_W'(mag[i]);
      end
   end

endmodule

// ----- rtl/pqd_queue.sv -----
module pqd_queue #(
   parameter int unsigned DEPTH = pqd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  pqd_pkg::pqd_item_type wr_data,
   input  logic                  pop,
   output logic                  empty,
   output pqd_pkg::pqd_item_type rd_data
);
   import pqd_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   pqd_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the incoming beat
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- rtl/pqd_back.sv -----
module pqd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_empty,
   output logic                  item_pop,
   input  pqd_pkg::pqd_item_type item,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output pqd_pkg::pqd_rsp_type  rsp_data
);
   import pqd_pkg::*;

   typedef struct packed {
      logic                          status;
      logic [LANE_IDX_W-1:0]         omitted;
      logic                          mirror;
      logic [RAD_W-1:0]              rad;
      logic [NUM_COMP-1:0][LANE_W-1:0] stored;
      logic [ROOT_ACC_W-1:0]         rem;
      logic [ROOT_ACC_W-1:0]         res;
   } stg_type;

   function automatic logic signed [LANE_W-1:0] neg_sat(logic signed [LANE_W-1:0] v);
      neg_sat = (v == LANE_MIN) ? LANE_MAX : -v;
   endfunction

   logic adv;

   // Stage 1: rounded stored values and sum of squares
   logic                            s1_vld_ff;
   logic [LANE_IDX_W-1:0]           s1_omitted_ff;
   logic                            s1_mirror_ff;
   logic [NUM_COMP-1:0][LANE_W-1:0] s1_stored_ff, s1_stored_in;
   logic [SUMSQ_W-1:0]              s1_sumsq_ff, s1_sumsq_in;
   logic [PROD_W-1:0]               rnd_sum [NUM_COMP];
   logic [MAG_Q_W-1:0]              rnd_mag [NUM_COMP];

   // Stage 2: sum of squares times squared scale
   logic                            s2_vld_ff;
   logic [LANE_IDX_W-1:0]           s2_omitted_ff;
   logic                            s2_mirror_ff;
   logic [NUM_COMP-1:0][LANE_W-1:0] s2_stored_ff;
   logic [TERM_PROD_W-1:0]          s2_prod_ff;

   // Radicand and root stages
   logic                 stg_vld_ff [SQRT_STEPS+1];
   stg_type              stg_ff     [SQRT_STEPS+1];
   stg_type              stg_in     [SQRT_STEPS+1];
   logic [TERM_PROD_W-1:0] term_sum;
   logic [RAD_W-1:0]       term;
   logic signed [RAD_W:0]  rad_diff;

   // Output register
   logic                 rsp_vld_ff;
   pqd_rsp_type          rsp_ff, rsp_in;
   logic [ROOT_ACC_W-1:0] root_rnd;
   logic signed [LANE_W-1:0] root;
   logic signed [LANE_W-1:0] lane_sel [4];

   // Advance the whole pipe unless a finished beat is stalled
   assign adv       = ~rsp_vld_ff | rsp_pop;
   assign item_pop  = adv & ~item_empty;
   assign rsp_empty = ~rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // Round scaled magnitudes, ties away from zero, and sum the squares
   always_comb begin
      for (int i = 0; i < NUM_COMP; i++) begin
         rnd_sum[i]      = item.prod[i] + (PROD_W'(1) << (ROUND_SHIFT - 1));
         rnd_mag[i]      = rnd_sum[i][ROUND_SHIFT +: MAG_Q_W];
         s1_stored_in[i] = item.neg[i] ? -{1'b0, rnd_mag[i]} : {1'b0, rnd_mag[i]};
      end
      s1_sumsq_in = SUMSQ_W'(item.sq[0]) + SUMSQ_W'(item.sq[1]) + SUMSQ_W'(item.sq[2]);
   end

   // Scale the sum, round, and subtract from one
   always_comb begin
      term_sum  = s2_prod_ff + (TERM_PROD_W'(1) << (TERM_SHIFT - 1));
      term      = term_sum[TERM_SHIFT +: RAD_W];
      rad_diff  = $signed({3'b001, {(RAD_W-2){1'b0}}}) - $signed({1'b0, term});
      stg_in[0].status  = rad_diff[RAD_W] ? STATUS_NEG : STATUS_OK;
      stg_in[0].omitted = s2_omitted_ff;
      stg_in[0].mirror  = s2_mirror_ff;
      stg_in[0].rad     = rad_diff[RAD_W-1:0];
      stg_in[0].stored  = s2_stored_ff;
      stg_in[0].rem     = rad_diff[RAD_W] ? '0 : rad_diff[ROOT_ACC_W-1:0];
      stg_in[0].res     = '0;
   end

   // One root bit per stage, largest trial first
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_root
      localparam logic [ROOT_ACC_W-1:0] BitVal =
         ROOT_ACC_W'(1) << (2 * (SQRT_STEPS - 1 - k));
      logic [ROOT_ACC_W:0] trial;
      logic                take;

      assign trial = {1'b0, stg_ff[k].res} + {1'b0, BitVal};
      assign take  = ({1'b0, stg_ff[k].rem} >= trial);

      always_comb begin
         stg_in[k+1] = stg_ff[k];
         if (take) begin
            stg_in[k+1].rem = stg_ff[k].rem - trial[ROOT_ACC_W-1:0];
            stg_in[k+1].res = (stg_ff[k].res >> 1) + BitVal;
         end else begin
            stg_in[k+1].res = stg_ff[k].res >> 1;
         end
      end
   end

   // Round the root, place lanes, apply mirror, zero all lanes on a negative radicand
   always_comb begin
      root_rnd = (stg_ff[SQRT_STEPS].rem > stg_ff[SQRT_STEPS].res) ?
                 stg_ff[SQRT_STEPS].res + 1'b1 : stg_ff[SQRT_STEPS].res;
      root     = (root_rnd > ROOT_ACC_W'(LANE_MAX)) ? LANE_MAX
                                                      : $signed(root_rnd[LANE_W-1:0]);
      lane_sel[0] = $signed(stg_ff[SQRT_STEPS].stored[0]);
      lane_sel[1] = $signed(stg_ff[SQRT_STEPS].stored[1]);
      lane_sel[2] = $signed(stg_ff[SQRT_STEPS].stored[2]);
      lane_sel[3] = $signed(stg_ff[SQRT_STEPS].stored[2]);
      case (stg_ff[SQRT_STEPS].omitted)
         2'd0: begin
            lane_sel[0] = root;
            lane_sel[1] = $signed(stg_ff[SQRT_STEPS].stored[0]);
            lane_sel[2] = $signed(stg_ff[SQRT_STEPS].stored[1]);
         end
         2'd1: begin
            lane_sel[1] = root;
            lane_sel[2] = $signed(stg_ff[SQRT_STEPS].stored[1]);
         end
         2'd2: lane_sel[2] = root;
         default: begin
            lane_sel[2] = $signed(stg_ff[SQRT_STEPS].stored[2]);
            lane_sel[3] = root;
         end
      endcase
      if (stg_ff[SQRT_STEPS].omitted != 2'd3) begin
         if (stg_ff[SQRT_STEPS].omitted == 2'd2) begin
            lane_sel[3] = $signed(stg_ff[SQRT_STEPS].stored[2]);
         end else begin
            lane_sel[3] = $signed(stg_ff[SQRT_STEPS].stored[2]);
         end
      end
      if (stg_ff[SQRT_STEPS].mirror) begin
         lane_sel[2] = neg_sat(lane_sel[2]);
         lane_sel[3] = neg_sat(lane_sel[3]);
      end
      rsp_in.status       = stg_ff[SQRT_STEPS].status;
      rsp_in.omitted_lane = stg_ff[SQRT_STEPS].omitted;
      rsp_in.radicand     = $signed(stg_ff[SQRT_STEPS].rad);
      if (stg_ff[SQRT_STEPS].status == STATUS_NEG) begin
         rsp_in.lane_0 = '0;
         rsp_in.lane_1 = '0;
         rsp_in.lane_2 = '0;
         rsp_in.lane_3 = '0;
      end else begin
         rsp_in.lane_0 = lane_sel[0];
         rsp_in.lane_1 = lane_sel[1];
         rsp_in.lane_2 = lane_sel[2];
         rsp_in.lane_3 = lane_sel[3];
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int k = 0; k <= SQRT_STEPS; k++) begin
            stg_vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         s1_vld_ff     <= ~item_empty;
         s2_vld_ff     <= s1_vld_ff;
         stg_vld_ff[0] <= s2_vld_ff;
         for (int k = 0; k < SQRT_STEPS; k++) begin
            stg_vld_ff[k+1] <= stg_vld_ff[k];
         end
         rsp_vld_ff <= stg_vld_ff[SQRT_STEPS];
      end
   end

   // Payload, held while the output beat is stalled
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_omitted_ff <= item.omitted;
         s1_mirror_ff  <= item.mirror;
         s1_stored_ff  <= s1_stored_in;
         s1_sumsq_ff   <= s1_sumsq_in;
         s2_omitted_ff <= s1_omitted_ff;
         s2_mirror_ff  <= s1_mirror_ff;
         s2_stored_ff  <= s1_stored_ff;
         s2_prod_ff    <= TERM_PROD_W'(s1_sumsq_ff) * TERM_PROD_W'(SCALE_SQ);
         for (int k = 0; k <= SQRT_STEPS; k++) begin
            stg_ff[k] <= stg_in[k];
         end
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- rtl/packed_quaternion_decode.sv -----
// Smallest-three quaternion decoder for 10:10:10:2 packed words.
// Request side is a queue write port: drive req_data and raise req_push;
// the beat is taken on a clock edge where req_full is low. Each beat holds
// the packed word (omitted lane index in bits 31:30, three offset 10-bit
// components below) and a mirror flag that negates lanes 2 and 3.
// Response side is a queue read port: while rsp_empty is low, rsp_data
// carries the oldest result (status, omitted lane, Q2.30 radicand, four
// Q1.15 lanes); raise rsp_pop to take it. Status 1 marks a negative
// radicand, with all lanes zero.
// A beat passes through the queue, the rounding and scale stages, the radicand
// stage, the 16-stage square root pipeline and the output register.
// One beat per cycle goes through while the output is not stalled; every stage is fully pipelined.
// When a response waits with rsp_pop low the back pipeline holds, and the front queue
// (QUEUE_DEPTH beats) keeps taking requests until req_full rises.
// Synchronous reset empties the queue and all pipeline stages.
module packed_quaternion_decode #(
   parameter int unsigned QUEUE_DEPTH = pqd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  pqd_pkg::pqd_req_type req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output pqd_pkg::pqd_rsp_type rsp_data
);
   import pqd_pkg::*;

   pqd_item_type front_item;
   pqd_item_type queue_item;
   logic         queue_empty;
   logic         queue_pop;

   pqd_front u_front (
      .req_data (req_data),
      .item     (front_item)
   );

   pqd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .full    (req_full),
      .wr_data (front_item),
      .pop     (queue_pop),
      .empty   (queue_empty),
      .rd_data (queue_item)
   );

   pqd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_empty (queue_empty),
      .item_pop   (queue_pop),
      .item       (queue_item),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- rtl/pqd_checker.sv -----
module pqd_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_full,
   input logic                 rsp_empty,
   input logic                 rsp_pop,
   input pqd_pkg::pqd_rsp_type rsp_data
);
   import pqd_pkg::*;

   // Hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled response changed");

   // Error status zeroes every lane
   a_err_lanes: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status == STATUS_NEG) |->
      (rsp_data.lane_0 == '0 && rsp_data.lane_1 == '0 &&
       rsp_data.lane_2 == '0 && rsp_data.lane_3 == '0))
      else $error("lanes not zero on negative radicand");

   // Status follows the radicand sign
   a_status_sign: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.status == rsp_data.radicand[RAD_W-1]))
      else $error("status disagrees with radicand sign");

   // Radicand never exceeds one
   a_rad_max: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.radicand <= 32'sh4000_0000))
      else $error("radicand above one");

   // Drop everything on reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

endmodule

bind packed_quaternion_decode pqd_checker u_checker (.*);

// ----- tb/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pqd_pkg::*;

   // Decoder arithmetic: component scale is SCALE_Q34 / 2^34
   localparam longint SCALE_Q34   = 64'sd23772998;
   localparam longint SCALE_SQ    = (SCALE_Q34 * SCALE_Q34 + (64'sd1 << 19)) >>> 20;
   localparam longint ONE_Q30     = 64'sd1 << 30;
   localparam int     COMP_BIAS   = 512;
   localparam int     DRAIN_WAIT  = 30;
   localparam int     CYCLE_LIMIT = 100000;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_push  = 1'b0;
   logic        req_full;
   pqd_req_type req_data  = '0;
   logic        rsp_empty;
   logic        rsp_pop   = 1'b0;
   pqd_rsp_type rsp_data;

   pqd_rsp_type expected_decodes[$];
   pqd_rsp_type want_rsp;

   int send_idle_pct   = 0;
   int pop_idle_pct    = 0;
   int pop_hold_len    = 0;
   int pop_hold_left   = 0;
   int words_sent      = 0;
   int results_checked = 0;
   int neg_results     = 0;
   int error_count     = 0;
   int mismatch_shown  = 0;
   int cycle_count     = 0;

   packed_quaternion_decode u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_decodes.size());
         $display("tb: failure");
         $finish;
      end
   end

   // Scale one signed component to Q1.15, rounding ties away from zero
   function automatic logic signed [LANE_W-1:0] scale_comp(input int p);
      longint mag;
      longint m;
      mag = (p < 0) ? -p : p;
      m = (mag * SCALE_Q34 + (64'sd1 << 18)) >>> 19;
      return LANE_W'((p < 0) ? -m : m);
   endfunction

   // Integer square root rounded to nearest, saturated to the Q1.15 maximum
   function automatic logic signed [LANE_W-1:0] root_q15(input longint r);
      longint root;
      longint trial;
      root = 0;
      for (int b = 15; b >= 0; b--) begin
         trial = root | (64'sd1 << b);
         if (trial * trial <= r) root = trial;
      end
      if (r - root * root > root) root = root + 1;
      if (root > 32767) root = 32767;
      return LANE_W'(root);
   endfunction

   // Full decode of one packed word
   function automatic pqd_rsp_type decode_quat(input pqd_req_type req);
      int                       p[3];
      logic signed [LANE_W-1:0] kept[3];
      logic signed [LANE_W-1:0] lanes[4];
      longint                   sumsq;
      longint                   rad;
      int                       k;
      pqd_rsp_type              rsp;
      p[0] = int'(req.packed_word[29:20]) - COMP_BIAS;
      p[1] = int'(req.packed_word[19:10]) - COMP_BIAS;
      p[2] = int'(req.packed_word[9:0]) - COMP_BIAS;
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
         kept[i] = scale_comp(p[i]);
         sumsq = sumsq + p[i] * p[i];
      end
      rad = ONE_Q30 - ((sumsq * SCALE_SQ + (64'sd1 << 17)) >>> 18);
      for (int i = 0; i < 4; i++) lanes[i] = '0;
      rsp.status       = (rad < 0) ? STATUS_NEG : STATUS_OK;
      rsp.omitted_lane = req.packed_word[31:30];
      rsp.radicand     = rad[31:0];
      if (rsp.status == STATUS_OK) begin
         k = 0;
         for (int i = 0; i < 4; i++) begin
            if (i == int'(rsp.omitted_lane)) begin
               lanes[i] = root_q15(rad);
            end else begin
               lanes[i] = kept[k];
               k++;
            end
         end
         if (req.mirror) begin
            for (int i = 2; i < 4; i++)
               lanes[i] = (lanes[i] == LANE_MIN) ? LANE_MAX : -lanes[i];
         end
      end
      rsp.lane_0 = lanes[0];
      rsp.lane_1 = lanes[1];
      rsp.lane_2 = lanes[2];
      rsp.lane_3 = lanes[3];
      return rsp;
   endfunction

   function automatic string rsp_text(input pqd_rsp_type r);
      return $sformatf("st=%0d om=%0d rad=%0d lanes=%0d %0d %0d %0d", r.status,
                       r.omitted_lane, r.radicand, r.lane_0, r.lane_1, r.lane_2, r.lane_3);
   endfunction

   function automatic pqd_req_type pack_beat(input logic [1:0] omitted, input logic [9:0] c0,
                                             input logic [9:0] c1, input logic [9:0] c2,
                                             input logic mirror);
      pqd_req_type req;
      req.packed_word = {omitted, c0, c1, c2};
      req.mirror      = mirror;
      return req;
   endfunction

   // Mix of raw words, small well-formed quaternions and near-unit edge cases
   function automatic pqd_req_type random_beat();
      pqd_req_type req;
      int          pick;
      int          hot;
      int          mag;
      int          c[3];
      req.packed_word = $urandom;
      req.mirror      = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         for (int i = 0; i < 3; i++) c[i] = COMP_BIAS - 300 + $urandom_range(0, 600);
         req.packed_word[29:0] = {c[0][9:0], c[1][9:0], c[2][9:0]};
      end else if (pick < 40) begin
         hot = $urandom_range(0, 2);
         for (int i = 0; i < 3; i++) begin
            if (i == hot) begin
               c[i] = COMP_BIAS - 20 + $urandom_range(0, 40);
            end else begin
               mag  = $urandom_range(500, 511);
               c[i] = $urandom_range(0, 1) ? COMP_BIAS + mag : COMP_BIAS - mag;
            end
         end
         req.packed_word[29:0] = {c[0][9:0], c[1][9:0], c[2][9:0]};
      end
      return req;
   endfunction

   // Offer one beat, idling at random first; leaves push high for the next beat
   task automatic push_beat(input pqd_req_type req);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= req;
      do @(posedge clock); while (req_full);
      expected_decodes.push_back(decode_quat(req));
      words_sent++;
   endtask

   // Drop push and hold until every outstanding result has been popped
   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_decodes.size() != 0) @(posedge clock);
   endtask

   // Result side: random pop, long hold-offs on request, and the compare
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_decodes.size() == 0) begin
               error_count++;
               if (mismatch_shown < 10)
                  $display("cycle %0d: unexpected result %s", cycle_count, rsp_text(rsp_data));
               mismatch_shown++;
            end else begin
               want_rsp = expected_decodes.pop_front();
               if (rsp_data.status !== want_rsp.status ||
                   rsp_data.omitted_lane !== want_rsp.omitted_lane ||
                   rsp_data.radicand !== want_rsp.radicand ||
                   rsp_data.lane_0 !== want_rsp.lane_0 ||
                   rsp_data.lane_1 !== want_rsp.lane_1 ||
                   rsp_data.lane_2 !== want_rsp.lane_2 ||
                   rsp_data.lane_3 !== want_rsp.lane_3) begin
                  error_count++;
                  if (mismatch_shown < 10)
                     $display("cycle %0d: decode mismatch\n  exp %s\n  got %s", cycle_count,
                              rsp_text(want_rsp), rsp_text(rsp_data));
                  mismatch_shown++;
               end
               results_checked++;
               if (want_rsp.status == STATUS_NEG) neg_results++;
            end
         end
         if (pop_hold_len != 0) begin
            pop_hold_left = pop_hold_len;
            pop_hold_len  = 0;
         end
         if (pop_hold_left != 0) begin
            pop_hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= pop_idle_pct);
         end
      end
   end

   // Unit radicand, extreme components, mirror, and the zero-radicand boundary
   task automatic test_directed();
      send_idle_pct = 0;
      pop_idle_pct  = 0;
      for (int l = 0; l < 4; l++)
         push_beat(pack_beat(2'(l), 10'd512, 10'd512, 10'd512, l >= 2));
      push_beat(pack_beat(2'd0, 10'd512, 10'd512, 10'd512, 1'b1));
      push_beat('{packed_word: 32'h0000_0000, mirror: 1'b0});
      push_beat('{packed_word: 32'hFFFF_FFFF, mirror: 1'b1});
      push_beat(pack_beat(2'd1, 10'd0, 10'd512, 10'd512, 1'b0));
      push_beat(pack_beat(2'd2, 10'd512, 10'd1023, 10'd512, 1'b1));
      push_beat(pack_beat(2'd3, 10'd512, 10'd512, 10'd0, 1'b1));
      push_beat(pack_beat(2'd0, 10'd1023, 10'd0, 10'd512, 1'b0));
      push_beat(pack_beat(2'd0, 10'd1023, 10'd1023, 10'd512, 1'b0));
      push_beat(pack_beat(2'd1, 10'd1, 10'd1, 10'd512, 1'b1));
      push_beat(pack_beat(2'd2, 10'd1023, 10'd1, 10'd512, 1'b0));
      push_beat(pack_beat(2'd3, 10'd1023, 10'd1022, 10'd512, 1'b1));
      push_beat(pack_beat(2'd1, 10'd1023, 10'd1023, 10'd513, 1'b0));
      push_beat(pack_beat(2'd3, 10'd512, 10'd1, 10'd1023, 1'b1));
      push_beat(pack_beat(2'd0, 10'd513, 10'd511, 10'd512, 1'b1));
      wait_drained();
   endtask

   // Random words under three idle mixes
   task automatic test_random();
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 60 : 0;
         pop_idle_pct  = (phase == 0) ? 60 : (phase == 1) ? 8 : 0;
         repeat (330) push_beat(random_beat());
      end
   endtask

   // Stall the result side long enough to fill the queue and block requests
   task automatic test_backpressure();
      send_idle_pct = 0;
      pop_idle_pct  = 0;
      pop_hold_len  = 250;
      repeat (60) push_beat(random_beat());
   endtask

   // Pause the sender until empty, then resume
   task automatic test_pause_resume();
      wait_drained();
      send_idle_pct = 20;
      pop_idle_pct  = 30;
      repeat (40) push_beat(random_beat());
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      test_backpressure();
      test_pause_resume();
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("decoded %0d words, checked %0d results (%0d with negative radicand)",
               words_sent, results_checked, neg_results);
      $display("covered unit radicand, extreme components, mirror, stalls and a full queue");
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d errors", error_count);
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- packed_quaternion_decode.f -----
rtl/pqd_pkg.sv
rtl/pqd_front.sv
rtl/pqd_queue.sv
rtl/pqd_back.sv
rtl/packed_quaternion_decode.sv
rtl/pqd_checker.sv
tb/testbench.sv
